// ----- hdl/tridiagonal_system_solver_defines.svh -----
// ----------------------------------------------------------------------------
// Tridiagonal system solver assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH

// same-cycle implication
`define TSS_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tss assertion failed");

// next-cycle implication
`define TSS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tss assertion failed");

`endif

// ----- hdl/tss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared widths, codes, control structs and saturation helper.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int TOL_W         = 16;
    localparam int ROW_W         = 6;
    localparam int STAT_W        = 2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_PIVOT = 2'd1;
    localparam logic [STAT_W-1:0] ST_ROWS  = 2'd2;

    localparam logic [1:0] MUL_A_C = 2'd0;
    localparam logic [1:0] MUL_A_D = 2'd1;
    localparam logic [1:0] MUL_C_X = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic       load;
        logic       piv_first;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       piv_ld;
        logic       num_ld;
        logic       div_start;
        logic       div_sel_num;
        logic       cq_ld;
        logic       wr;
        logic       x_from_ram;
        logic       x_ld;
        logic       x_clr;
    } t_cmd;

    typedef struct packed {
        logic piv_bad;
        logic div_done;
        logic last;
    } t_stat;

    function automatic t_data sat65(input logic signed [64:0] v);
        t_data res;
        if (v > 65'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -65'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = t_data'(v[31:0]);
        end
        return res;
    endfunction

endpackage

// ----- hdl/tridiagonal_system_solver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal system solver
// Thomas algorithm in signed fixed point, one matrix row per request.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  request   | start & !busy              | i_sub/main/super_diagonal,
//            |                            | i_right_side, i_last_row
//  result    | o_result_strobe, 1 cycle   | o_row_index, o_solution,
//            |                            | o_last_result, o_status
//  config    | i_cfg_we                   | i_cfg_wdata (pivot tolerance)
//
//  A row request is done before the next is accepted: two serial divisions
//  by the pivot on the one restoring divider; row zero skips the elimination
//  multiplies and the last row skips the first division. Back substitution
//  then emits one solution at a time from the store, last row first. An
//  errored or surplus row is absorbed without a solve; reset is synchronous,
//  active low. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver import tss_pkg::*; #(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_data             i_sub_diagonal,
    input  t_data             i_main_diagonal,
    input  t_data             i_super_diagonal,
    input  t_data             i_right_side,
    input  logic              i_last_row,
    input  logic              i_cfg_we,
    input  logic [TOL_W-1:0]  i_cfg_wdata,
    output logic              o_result_strobe,
    output logic [ROW_W-1:0]  o_row_index,
    output t_data             o_solution,
    output logic              o_last_result,
    output logic [STAT_W-1:0] o_status
);
`include "tridiagonal_system_solver_defines.svh"

    localparam int AW = $clog2(MAX_ROWS);

    // command and status between sequencer and datapath
    t_cmd          cmd;
    t_stat         stat;
    logic [AW-1:0] addr;

    tss_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_last_row    (i_last_row),
        .i_stat        (stat),
        .o_busy        (busy),
        .o_cmd         (cmd),
        .o_addr        (addr),
        .o_strobe      (o_result_strobe),
        .o_row_index   (o_row_index),
        .o_last_result (o_last_result),
        .o_status      (o_status)
    );

    tss_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_addr           (addr),
        .i_sub_diagonal   (i_sub_diagonal),
        .i_main_diagonal  (i_main_diagonal),
        .i_super_diagonal (i_super_diagonal),
        .i_right_side     (i_right_side),
        .i_last_row       (i_last_row),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_stat           (stat),
        .o_solution       (o_solution)
    );

    // an error result stands alone: row zero, zero value, final
    `TSS_ASSERT_NOW(a_err_result, i_clk, i_rst_n,
        o_result_strobe && (o_status != ST_OK),
        o_last_result && (o_row_index == '0) && (o_solution == '0))
    // results only come out of work started while busy
    `TSS_ASSERT_NOW(a_strobe_busy, i_clk, i_rst_n, o_result_strobe, $past(busy))
    // an accepted final row always makes the block busy
    `TSS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy && i_last_row, busy)
    // the final result of a solve is shown while the block is already idle
    `TSS_ASSERT_NOW(a_last_idle, i_clk, i_rst_n,
        o_result_strobe && o_last_result, !busy)
endmodule

// ----- hdl/tss_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/tss_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal solver datapath
// Row registers, shared multiplier, saturating subtract, serial divider, stores.
// ----------------------------------------------------------------------------
module tss_datapath import tss_pkg::*; #(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    localparam int AW = $clog2(MAX_ROWS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [AW-1:0]      i_addr,
    input  t_data              i_sub_diagonal,
    input  t_data              i_main_diagonal,
    input  t_data              i_super_diagonal,
    input  t_data              i_right_side,
    input  logic               i_last_row,
    input  logic               i_cfg_we,
    input  logic [TOL_W-1:0]   i_cfg_wdata,
    output t_stat              o_stat,
    output t_data              o_solution
);
    localparam int DIV_W = DATA_W + FRAC_BITS;
    localparam int DCW   = $clog2(DIV_W);

    t_data r_a, r_b, r_c, r_r, r_piv, r_num, r_cq, r_x;
    logic  r_last;
    logic [TOL_W-1:0] r_tol;
    logic signed [63:0] r_prod;
    t_data rd_c, rd_d, op0, op1, base, div_res, div_num;
    logic signed [63:0] prod_sh;
    logic signed [64:0] diff;
    t_data sat_diff;

    logic [DATA_W:0]    r_rem;
    logic [DIV_W-1:0]   r_dq;
    logic [DATA_W-1:0]  r_den;
    logic               r_neg, r_dbusy, r_ddone;
    logic [DCW-1:0]     r_dcnt;
    logic [DATA_W:0]    rem_sh;
    logic               ge;
    logic [DATA_W-1:0]  n_mag, d_mag;
    logic [DATA_W:0]    piv_mag;
    logic               q_ovf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= i_sub_diagonal;
            r_b    <= i_main_diagonal;
            r_c    <= i_super_diagonal;
            r_r    <= i_right_side;
            r_last <= i_last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    tss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_upper (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (i_addr),
        .i_wdata (r_last ? '0 : r_cq),
        .i_raddr (i_addr),
        .o_rdata (rd_c)
    );

    tss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_rhs (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (i_addr),
        .i_wdata (div_res),
        .i_raddr (i_addr),
        .o_rdata (rd_d)
    );

    // shared multiplier, registered product
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_A_C: begin op0 = r_a;  op1 = rd_c; end
            MUL_A_D: begin op0 = r_a;  op1 = rd_d; end
            MUL_C_X: begin op0 = rd_c; op1 = r_x;  end
            default: begin op0 = '0;   op1 = '0;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= 64'(op0) * 64'(op1);
        end
    end

    // floor shift, then saturating subtract
    assign prod_sh = r_prod >>> FRAC_BITS;

    always_comb begin
        if (i_cmd.piv_ld) begin
            base = r_b;
        end else if (i_cmd.num_ld) begin
            base = r_r;
        end else begin
            base = rd_d;
        end
    end

    assign diff     = {base[DATA_W-1], {(64-DATA_W){base[DATA_W-1]}}, base}
                      - {prod_sh[63], prod_sh};
    assign sat_diff = sat65(diff);

    always_ff @(posedge i_clk) begin
        if (i_cmd.piv_first) begin
            r_piv <= r_b;
            r_num <= r_r;
        end else begin
            if (i_cmd.piv_ld) r_piv <= sat_diff;
            if (i_cmd.num_ld) r_num <= sat_diff;
        end
        if (i_cmd.x_from_ram) begin
            r_x <= rd_d;
        end else if (i_cmd.x_ld) begin
            r_x <= sat_diff;
        end else if (i_cmd.x_clr) begin
            r_x <= '0;
        end
        if (i_cmd.cq_ld) begin
            r_cq <= div_res;
        end
    end

    assign piv_mag = r_piv[DATA_W-1] ? (DATA_W+1)'(-{r_piv[DATA_W-1], r_piv})
                                     : {1'b0, r_piv};

    // restoring divider, one quotient bit per cycle
    assign div_num = i_cmd.div_sel_num ? r_num : r_c;
    assign n_mag   = div_num[DATA_W-1] ? DATA_W'(-div_num) : DATA_W'(div_num);
    assign d_mag   = piv_mag[DATA_W-1:0];
    assign rem_sh  = {r_rem[DATA_W-1:0], r_dq[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_ddone <= 1'b0;
            r_dcnt  <= '0;
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt + DCW'(1);
            if (r_dcnt == DCW'(DIV_W - 1)) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq  <= {n_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= d_mag;
            r_neg <= div_num[DATA_W-1] ^ r_piv[DATA_W-1];
        end else if (r_dbusy) begin
            r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
            r_dq  <= {r_dq[DIV_W-2:0], ge};
        end
    end

    always_comb begin
        if (r_neg) begin
            q_ovf   = (|r_dq[DIV_W-1:DATA_W]) || (r_dq[DATA_W-1] && |r_dq[DATA_W-2:0]);
            div_res = q_ovf ? 32'sh80000000 : t_data'(-r_dq[DATA_W-1:0]);
        end else begin
            q_ovf   = |r_dq[DIV_W-1:DATA_W-1];
            div_res = q_ovf ? 32'sh7FFFFFFF : t_data'(r_dq[DATA_W-1:0]);
        end
    end

    assign o_stat.piv_bad  = (r_piv == '0) || (piv_mag < (DATA_W+1)'(r_tol));
    assign o_stat.div_done = r_ddone;
    assign o_stat.last     = r_last;
    assign o_solution      = r_x;
endmodule

// ----- hdl/tss_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal solver controller
// Sequences forward sweep, back substitution and result strobes.
// ----------------------------------------------------------------------------
module tss_ctrl import tss_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int AW = $clog2(MAX_ROWS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_last_row,
    input  t_stat             i_stat,
    output logic              o_busy,
    output t_cmd              o_cmd,
    output logic [AW-1:0]     o_addr,
    output logic              o_strobe,
    output logic [ROW_W-1:0]  o_row_index,
    output logic              o_last_result,
    output logic [STAT_W-1:0] o_status
);
    localparam int CW = $clog2(MAX_ROWS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_MA    = 4'd3;
    localparam logic [3:0] S_SP    = 4'd4;
    localparam logic [3:0] S_SN    = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_DVC   = 4'd7;
    localparam logic [3:0] S_DVD   = 4'd8;
    localparam logic [3:0] S_BS0   = 4'd9;
    localparam logic [3:0] S_BX0   = 4'd10;
    localparam logic [3:0] S_BRD   = 4'd11;
    localparam logic [3:0] S_BML   = 4'd12;
    localparam logic [3:0] S_BSB   = 4'd13;
    localparam logic [3:0] S_ERR   = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt, cnt_m1, cnt_m2;
    logic [STAT_W-1:0] r_err, n_err;
    logic [AW-1:0]     r_k, n_k;
    logic              r_strobe, n_strobe, r_lastr, n_lastr;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [STAT_W-1:0] r_status, n_status;
    logic [AW+ROW_W-1:0] row_ext_m1, row_ext_k;

    assign cnt_m1     = r_cnt - CW'(1);
    assign cnt_m2     = r_cnt - CW'(2);
    assign row_ext_m1 = {{ROW_W{1'b0}}, cnt_m1[AW-1:0]};
    assign row_ext_k  = {{ROW_W{1'b0}}, r_k};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_err    = r_err;
        n_k      = r_k;
        n_strobe = 1'b0;
        n_lastr  = r_lastr;
        n_row    = r_row;
        n_status = r_status;
        o_cmd    = '0;
        o_addr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (r_err != ST_OK) begin
                        n_state = i_last_row ? S_ERR : S_IDLE;
                    end else if (r_cnt == CW'(MAX_ROWS)) begin
                        n_err   = ST_ROWS;
                        n_state = i_last_row ? S_ERR : S_IDLE;
                    end else if (r_cnt == '0) begin
                        n_state = S_FIRST;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_FIRST: begin
                o_cmd.piv_first = 1'b1;
                n_state = S_CHK;
            end
            S_RD: begin
                o_addr  = cnt_m1[AW-1:0];
                n_state = S_MA;
            end
            S_MA: begin
                o_addr         = cnt_m1[AW-1:0];
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_A_C;
                n_state        = S_SP;
            end
            S_SP: begin
                o_addr        = cnt_m1[AW-1:0];
                o_cmd.piv_ld  = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_A_D;
                n_state       = S_SN;
            end
            S_SN: begin
                o_cmd.num_ld = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                if (i_stat.piv_bad) begin
                    n_err   = ST_PIVOT;
                    n_state = i_stat.last ? S_ERR : S_IDLE;
                end else begin
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel_num = i_stat.last;
                    n_state           = i_stat.last ? S_DVD : S_DVC;
                end
            end
            S_DVC: begin
                if (i_stat.div_done) begin
                    o_cmd.cq_ld       = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_sel_num = 1'b1;
                    n_state           = S_DVD;
                end
            end
            S_DVD: begin
                o_addr = r_cnt[AW-1:0];
                if (i_stat.div_done) begin
                    o_cmd.wr = 1'b1;
                    n_cnt    = r_cnt + CW'(1);
                    n_state  = i_stat.last ? S_BS0 : S_IDLE;
                end
            end
            S_BS0: begin
                o_addr  = cnt_m1[AW-1:0];
                n_state = S_BX0;
            end
            S_BX0: begin
                o_addr           = cnt_m1[AW-1:0];
                o_cmd.x_from_ram = 1'b1;
                n_strobe         = 1'b1;
                n_row            = row_ext_m1[ROW_W-1:0];
                n_status         = ST_OK;
                n_k              = cnt_m2[AW-1:0];
                if (r_cnt == CW'(1)) begin
                    n_lastr = 1'b1;
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_lastr = 1'b0;
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                o_addr  = r_k;
                n_state = S_BML;
            end
            S_BML: begin
                o_addr        = r_k;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_C_X;
                n_state       = S_BSB;
            end
            S_BSB: begin
                o_addr     = r_k;
                o_cmd.x_ld = 1'b1;
                n_strobe   = 1'b1;
                n_row      = row_ext_k[ROW_W-1:0];
                n_status   = ST_OK;
                if (r_k == '0) begin
                    n_lastr = 1'b1;
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_lastr = 1'b0;
                    n_k     = r_k - AW'(1);
                    n_state = S_BRD;
                end
            end
            S_ERR: begin
                o_cmd.x_clr = 1'b1;
                n_strobe    = 1'b1;
                n_row       = '0;
                n_lastr     = 1'b1;
                n_status    = r_err;
                n_err       = ST_OK;
                n_cnt       = '0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_err    <= ST_OK;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_err    <= n_err;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_row    <= n_row;
        r_lastr  <= n_lastr;
        r_status <= n_status;
    end

    assign o_busy        = r_state != S_IDLE;
    assign o_strobe      = r_strobe;
    assign o_row_index   = r_row;
    assign o_last_result = r_lastr;
    assign o_status      = r_status;
endmodule

// ----- tb/tridiagonal_system_solver_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tridiagonal system solver testbench
// Streams matrix rows into the solver and checks every emitted solution
// against an in-bench fixed-point Thomas solver, across tolerance settings.
// ----------------------------------------------------------------------------

// Expected solutions of the systems sent so far, oldest first.
class solution_board;
    typedef struct {
        logic [tss_pkg::ROW_W-1:0]  row;
        tss_pkg::t_data             value;
        logic                       last;
        logic [tss_pkg::STAT_W-1:0] status;
    } t_solution;

    t_solution            pending[$];
    tss_pkg::t_data       upper_q[64];
    tss_pkg::t_data       rhs_q[64];
    int unsigned          rows_held;
    logic [1:0]           fault;
    logic [15:0]          tolerance;
    int unsigned          failures;

    function new();
        rows_held = 0;
        fault     = tss_pkg::ST_OK;
        tolerance = 16'd1;
        failures  = 0;
    endfunction

    // clamp to the 32-bit signed range
    function tss_pkg::t_data clamp(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return tss_pkg::t_data'(v);
    endfunction

    // Q16.16 product, floor rounding (arithmetic shift)
    function longint fx_mul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    // Q16.16 quotient, truncated toward zero, then clamped
    function tss_pkg::t_data fx_div(longint num, longint den);
        longint scaled;
        scaled = num <<< 16;
        return clamp(scaled / den);
    endfunction

    function void push(logic [5:0] row, tss_pkg::t_data v, logic last, logic [1:0] st);
        t_solution s;
        s.row = row; s.value = v; s.last = last; s.status = st;
        pending.push_back(s);
    endfunction

    // Run the forward sweep for one accepted row; on the last row, queue
    // the back-substituted solutions (or the single error result).
    function void note_row(tss_pkg::t_data a, tss_pkg::t_data b, tss_pkg::t_data c,
                           tss_pkg::t_data r, logic last);
        longint pivot;
        longint num;
        longint mag;
        int unsigned k;
        tss_pkg::t_data x;
        if (fault == tss_pkg::ST_OK) begin
            if (rows_held >= 64) begin
                fault = tss_pkg::ST_ROWS;
            end else begin
                if (rows_held == 0) begin
                    pivot = b;
                    num   = r;
                end else begin
                    pivot = clamp(longint'(b) - fx_mul(a, upper_q[rows_held-1]));
                    num   = clamp(longint'(r) - fx_mul(a, rhs_q[rows_held-1]));
                end
                mag = (pivot < 0) ? -pivot : pivot;
                if (pivot == 0 || mag < longint'(tolerance)) begin
                    fault = tss_pkg::ST_PIVOT;
                end else begin
                    upper_q[rows_held] = last ? '0 : fx_div(c, pivot);
                    rhs_q[rows_held]   = fx_div(num, pivot);
                    rows_held++;
                end
            end
        end
        if (!last) return;
        if (fault != tss_pkg::ST_OK) begin
            push(6'd0, '0, 1'b1, fault);
        end else begin
            k = rows_held;
            x = rhs_q[k-1];
            push(6'(k-1), x, k == 1, tss_pkg::ST_OK);
            while (k > 1) begin
                k--;
                x = clamp(longint'(rhs_q[k-1]) - fx_mul(upper_q[k-1], x));
                push(6'(k-1), x, k == 1, tss_pkg::ST_OK);
            end
        end
        rows_held = 0;
        fault     = tss_pkg::ST_OK;
    endfunction

    function void check_result(logic [5:0] row, tss_pkg::t_data v, logic last,
                               logic [1:0] st);
        t_solution e;
        if (pending.size() == 0) begin
            $error("unexpected result: row_index %0d solution %0d", row, v);
            failures++;
            return;
        end
        e = pending.pop_front();
        if (row !== e.row) begin
            $error("row_index: expected %0d, actual %0d", e.row, row);
            failures++;
        end
        if (v !== e.value) begin
            $error("solution: expected %0d, actual %0d", e.value, v);
            failures++;
        end
        if (last !== e.last) begin
            $error("last_result: expected %0d, actual %0d", e.last, last);
            failures++;
        end
        if (st !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, st);
            failures++;
        end
    endfunction
endclass

module tridiagonal_system_solver_tb;
    import tss_pkg::*;

    localparam int ROWS_TARGET = 480;
    // longest row request plus a full back-substitution pass, with margin
    localparam int SETTLE      = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_data             i_sub_diagonal;
    t_data             i_main_diagonal;
    t_data             i_super_diagonal;
    t_data             i_right_side;
    logic              i_last_row;
    logic              i_cfg_we;
    logic [TOL_W-1:0]  i_cfg_wdata;
    logic              o_result_strobe;
    logic [ROW_W-1:0]  o_row_index;
    t_data             o_solution;
    logic              o_last_result;
    logic [STAT_W-1:0] o_status;

    solution_board board;
    int unsigned   rows_sent;
    bit            idle_enable;

    tridiagonal_system_solver u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_sub_diagonal   (i_sub_diagonal),
        .i_main_diagonal  (i_main_diagonal),
        .i_super_diagonal (i_super_diagonal),
        .i_right_side     (i_right_side),
        .i_last_row       (i_last_row),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_result_strobe  (o_result_strobe),
        .o_row_index      (o_row_index),
        .o_solution       (o_solution),
        .o_last_result    (o_last_result),
        .o_status         (o_status)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Results cannot be held off: check each strobe as it goes by.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            board.check_result(o_row_index, o_solution, o_last_result, o_status);
        end
    end

    // Offer one row request; hold it until the solver takes it.
    task automatic send_row(t_data a, t_data b, t_data c, t_data r, logic last);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        start            = 1'b1;
        i_sub_diagonal   = a;
        i_main_diagonal  = b;
        i_super_diagonal = c;
        i_right_side     = r;
        i_last_row       = last;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        board.note_row(a, b, c, r, last);
        rows_sent++;
        @(negedge i_clk);
    endtask

    // Drain all results, let absorbed rows finish, then stay quiet.
    task automatic drain();
        start = 1'b0;
        while (board.pending.size() != 0 || busy) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Write the tolerance only while the solver is idle.
    task automatic set_tolerance(logic [15:0] tol);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = tol;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        board.tolerance = tol;
    endtask

    // Well-conditioned row: dominant diagonal, modest off-diagonals.
    task automatic send_good_row(logic last);
        t_data a, b, c, r;
        a = t_data'($signed($urandom_range(0, 32'h0003_0000))) - 32'sh0001_8000;
        c = t_data'($signed($urandom_range(0, 32'h0003_0000))) - 32'sh0001_8000;
        b = t_data'($urandom_range(32'h0004_0000, 32'h0040_0000));
        if ($urandom_range(0, 1)) b = -b;
        r = ($urandom_range(0, 7) == 0) ? t_data'($urandom)
                                        : t_data'($signed($urandom_range(0, 32'h00FF_FFFF)))
                                          - 32'sh0080_0000;
        send_row(a, b, c, r, last);
    endtask

    task automatic send_system(int unsigned n, int unsigned noise_pct);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_row(t_data'($urandom), t_data'($urandom), t_data'($urandom),
                         t_data'($urandom), k == n - 1);
            end else begin
                send_good_row(k == n - 1);
            end
        end
    endtask

    initial begin
        int unsigned len;
        board            = new();
        rows_sent        = 0;
        idle_enable      = 1'b0;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_sub_diagonal   = '0;
        i_main_diagonal  = '0;
        i_super_diagonal = '0;
        i_right_side     = '0;
        i_last_row       = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: single-row systems at the field extremes.
        send_row(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1);
        send_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1);
        send_row('0, 32'sh0000_0001, '0, 32'sh7FFFFFFF, 1'b1);
        // Zero pivot on row zero, then rows absorbed until the last one.
        send_row('0, '0, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_row(32'sh0001_0000, 32'sh0002_0000, '0, 32'sh0001_0000, 1'b0);
        send_row(32'sh0001_0000, 32'sh0002_0000, '0, 32'sh0001_0000, 1'b1);
        // Pivot cancels to zero on a later row.
        send_row('0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_row(32'sh0001_0000, 32'sh0001_0000, '0, 32'sh0002_0000, 1'b1);
        // Plain two- and three-row systems.
        send_row('0, 32'sh0004_0000, 32'sh0001_0000, 32'sh0003_0000, 1'b0);
        send_row(32'sh0001_0000, 32'sh0004_0000, '0, 32'sh0005_0000, 1'b1);
        send_system(3, 0);

        // Tolerance zero: a zero pivot is still flagged, a tiny one is not.
        set_tolerance(16'd0);
        send_row('0, '0, '0, 32'sh0001_0000, 1'b1);
        send_row('0, 32'sh0000_0001, '0, 32'sh0000_0001, 1'b1);
        // Largest tolerance: just below and at the limit.
        set_tolerance(16'hFFFF);
        send_row('0, 32'sh0000_FFFE, '0, 32'sh0001_0000, 1'b1);
        send_row('0, -32'sh0000_FFFF, '0, 32'sh0001_0000, 1'b1);
        send_row('0, 32'sh0000_FFFF, 32'sh0000_1000, 32'sh0001_0000, 1'b0);
        send_row(32'sh0000_1000, 32'sh0000_FFFF, '0, 32'sh0001_0000, 1'b1);
        set_tolerance(16'd1);

        // Too many rows: one full store, then one more.
        send_system(64, 0);
        send_system(65, 0);

        // Random systems, mostly short, with idle bursts on the request side.
        idle_enable = 1'b1;
        while (rows_sent < ROWS_TARGET) begin
            if (rows_sent > ROWS_TARGET - 60) idle_enable = 1'b0;
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 3))
                    0: set_tolerance(16'd0);
                    1: set_tolerance(16'hFFFF);
                    default: set_tolerance(16'($urandom_range(0, 16'hFFFF)));
                endcase
            end
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(7, 20);
                1:       len = $urandom_range(1, 3);
                default: len = $urandom_range(1, 6);
            endcase
            send_system(len, ($urandom_range(0, 5) == 0) ? 60 : 8);
        end
        drain();

        if (board.failures == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
